@@ hdl/tps_pkg.sv @@
// Package for the task priority scheduler: field widths, default sizes,
// command codes and controller states. No dependencies.
package tps_pkg;

  localparam int TASK_SLOTS_DEF    = 256;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int USER_BITS_DEF     = 16;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 8;
  localparam int FIELD_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_EDIT   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_EXEC   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_USER,
    S_OUT
  } state_t;

endpackage

@@ hdl/tps_if.sv @@
// Valid/ready channel interfaces for the scheduler's command and result words.
// Depends on tps_pkg for field widths.
interface tps_in_if import tps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ID_W-1:0]    task_id;
  logic [FIELD_W-1:0] user_id;
  logic [FIELD_W-1:0] priority_req;

  modport source (output valid, command, task_id, user_id, priority_req, input ready);
  modport sink   (input valid, command, task_id, user_id, priority_req, output ready);
endinterface

interface tps_out_if import tps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [FIELD_W-1:0] owner_user;

  modport source (output valid, found, owner_user, input ready);
  modport sink   (input valid, found, owner_user, output ready);
endinterface

@@ hdl/task_priority_scheduler_top.sv @@
// Task priority scheduler: task table in two synchronous memories with
// flip-flop valid bits and a sequential maximum search. Depends on tps_pkg, tps_if.
//
// Usage:
//   in_ch  carries command words (add, edit priority, remove, execute top).
//   out_ch carries one result word per execute-top: found and owner_user.
//   Add, edit and remove produce no result; the next word is taken in the
//   following cycle.
//   Execute-top walks the priority memory one slot a cycle, one read port,
//   then reads the winner's user and loads the result into the output
//   register. in_ch is not ready during the walk.
//   Ties go to the larger task id. An empty table returns found = 0, user 0.
//   A result waits in the output register while out_ch stalls; further add,
//   edit and remove words are still taken, and a following execute-top
//   holds its result until the register is free.
//   Reset clears all valid bits at once; no clearing pass is needed.
module task_priority_scheduler_top import tps_pkg::*; #(
  parameter int TASK_SLOTS    = TASK_SLOTS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int USER_BITS     = USER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tps_in_if.sink     in_ch,
  tps_out_if.source  out_ch
);

  localparam int IDX_W    = $clog2(TASK_SLOTS);
  localparam int ID_EXT_W = (IDX_W > ID_W) ? IDX_W : ID_W;
  localparam int PW       = (PRIORITY_BITS < FIELD_W) ? PRIORITY_BITS : FIELD_W;
  localparam int UW       = (USER_BITS < FIELD_W) ? USER_BITS : FIELD_W;

  logic [UW-1:0] user_mem [TASK_SLOTS];
  logic [PW-1:0] prio_mem [TASK_SLOTS];

  logic [TASK_SLOTS-1:0] valid_r;
  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      scan_idx_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  pend_r;
  logic [PW-1:0]         prio_rd_r;
  logic [UW-1:0]         user_rd_r;
  logic                  any_r;
  logic [IDX_W-1:0]      best_r;
  logic [PW-1:0]         best_prio_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [FIELD_W-1:0]    out_user_r;

  logic [ID_EXT_W-1:0] id_ext;
  logic [IDX_W-1:0]    idx;
  logic                in_table;
  logic                in_fire;
  cmd_t                cmd;
  logic                out_free;
  logic                out_load;
  logic                usr_rd;
  logic                take;

  assign id_ext   = ID_EXT_W'(in_ch.task_id);
  assign idx      = id_ext[IDX_W-1:0];
  assign in_table = (32'(id_ext) < 32'(TASK_SLOTS));
  assign cmd      = cmd_t'(in_ch.command);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign take     = pend_r && valid_r[rd_idx_r] && (!any_r || prio_rd_r >= best_prio_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    usr_rd      = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && cmd == CMD_EXEC) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx_r == IDX_W'(TASK_SLOTS - 1)) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_USER;
      end
      S_USER: begin
        usr_rd    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // valid bits: set by add, cleared by remove on accept, winner cleared on result load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (in_fire && in_table && cmd == CMD_ADD) begin
        valid_r[idx] <= 1'b1;
      end
      if (in_fire && in_table && cmd == CMD_REMOVE) begin
        valid_r[idx] <= 1'b0;
      end
      if (out_load && any_r) begin
        valid_r[best_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_table && cmd == CMD_ADD) begin
      user_mem[idx] <= in_ch.user_id[UW-1:0];
    end
    if (usr_rd) begin
      user_rd_r <= user_mem[best_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_table &&
        (cmd == CMD_ADD || (cmd == CMD_EDIT && valid_r[idx]))) begin
      prio_mem[idx] <= in_ch.priority_req[PW-1:0];
    end
    if (state_r == S_SCAN) begin
      prio_rd_r <= prio_mem[scan_idx_r];
    end
  end

  // maximum search, compare in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      any_r      <= 1'b0;
      scan_idx_r <= '0;
    end else begin
      pend_r <= (state_r == S_SCAN);
      if (in_fire && cmd == CMD_EXEC) begin
        any_r      <= 1'b0;
        scan_idx_r <= '0;
      end else if (state_r == S_SCAN) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (take) begin
        any_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
    if (take) begin
      best_r      <= rd_idx_r;
      best_prio_r <= prio_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= any_r;
      out_user_r  <= any_r ? FIELD_W'(user_rd_r) : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.owner_user = out_user_r;

  a_empty_zero_user: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.found |-> out_ch.owner_user == '0)
    else $error("not-found result carries a nonzero user");

  a_exec_clears_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && any_r |=> $countones(valid_r) == $past($countones(valid_r)) - 1)
    else $error("executed task not removed from table");

  a_scan_table_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && $past(state_r == S_SCAN) |-> $stable(valid_r))
    else $error("valid bits changed during search");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready)
    else $error("command taken while search in progress");

endmodule
